[rtl/bsrd_pkg.sv]
// Shared types and constants for the background-subtracting run detector.
// No dependencies; the other files of the block, bsrd_ram apart, refer to it by scoped names.
package bsrd_pkg;

   localparam int RANGE_W     = 16;
   localparam int INDEX_W     = 10;
   localparam int TOL_W       = 16;
   localparam int MINLEN_W    = 8;
   localparam int RATIO_W     = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_INDEX_W = 2;

   // register indexes (byte address / 4)
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_RUN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RATIO_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RATIO_HIGH = 2'd3;

   localparam logic [TOL_W-1:0]    TOLERANCE_RESET  = 16'd100;
   localparam logic [MINLEN_W-1:0] MIN_RUN_RESET    = 8'd5;
   localparam logic [RATIO_W-1:0]  RATIO_LOW_RESET  = 8'd7;
   localparam logic [RATIO_W-1:0]  RATIO_HIGH_RESET = 8'd13;

   localparam logic OP_LEARN   = 1'b0;
   localparam logic OP_PROCESS = 1'b1;

   // ratio bounds are in tenths
   localparam int TENTHS = 10;

   typedef struct packed {
      logic [TOL_W-1:0]    background_tolerance;
      logic [MINLEN_W-1:0] min_run_length;
      logic [RATIO_W-1:0]  ratio_low_tenths;
      logic [RATIO_W-1:0]  ratio_high_tenths;
   } cfg_type;

   // one request as it reaches the run tracker
   typedef struct packed {
      logic               proc;
      logic               last;
      logic [RANGE_W-1:0] kept;
   } item_type;

endpackage

[rtl/bsrd_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module bsrd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/bsrd_csr.sv]
// Configuration registers behind the APB-style port.
// Uses bsrd_pkg for register indexes, reset values and the config struct.
module bsrd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bsrd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bsrd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bsrd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output bsrd_pkg::cfg_type              cfg
);

   bsrd_pkg::cfg_type cfg_ff, cfg_in;
   logic [bsrd_pkg::CSR_INDEX_W-1:0] index;
   logic wr;

   assign index = csr_paddr[bsrd_pkg::CSR_ADDR_W-1:2];
   assign wr    = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (index)
            bsrd_pkg::REG_TOLERANCE:
               cfg_in.background_tolerance = csr_pwdata[bsrd_pkg::TOL_W-1:0];
            bsrd_pkg::REG_MIN_RUN:
               cfg_in.min_run_length = csr_pwdata[bsrd_pkg::MINLEN_W-1:0];
            bsrd_pkg::REG_RATIO_LOW:
               cfg_in.ratio_low_tenths = csr_pwdata[bsrd_pkg::RATIO_W-1:0];
            bsrd_pkg::REG_RATIO_HIGH:
               cfg_in.ratio_high_tenths = csr_pwdata[bsrd_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.background_tolerance <= bsrd_pkg::TOLERANCE_RESET;
         cfg_ff.min_run_length       <= bsrd_pkg::MIN_RUN_RESET;
         cfg_ff.ratio_low_tenths     <= bsrd_pkg::RATIO_LOW_RESET;
         cfg_ff.ratio_high_tenths    <= bsrd_pkg::RATIO_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         bsrd_pkg::REG_TOLERANCE:
            csr_prdata = bsrd_pkg::CSR_DATA_W'(cfg_ff.background_tolerance);
         bsrd_pkg::REG_MIN_RUN:
            csr_prdata = bsrd_pkg::CSR_DATA_W'(cfg_ff.min_run_length);
         bsrd_pkg::REG_RATIO_LOW:
            csr_prdata = bsrd_pkg::CSR_DATA_W'(cfg_ff.ratio_low_tenths);
         bsrd_pkg::REG_RATIO_HIGH:
            csr_prdata = bsrd_pkg::CSR_DATA_W'(cfg_ff.ratio_high_tenths);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bsrd_run.sv]
// Run tracker: run length, run sum and the ratio test by cross-multiplication.
// Uses bsrd_pkg for the config and request structs.
module bsrd_run #(
   parameter int SCAN_LEN = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  bsrd_pkg::item_type item,
   input  bsrd_pkg::cfg_type  cfg,
   output logic               emit
);

   localparam int RL_W  = $clog2(SCAN_LEN + 1);
   localparam int X10_W = $clog2(bsrd_pkg::TENTHS * SCAN_LEN + 1);
   localparam int SUM_W = bsrd_pkg::RANGE_W + RL_W;
   localparam int LEN_W = (RL_W > bsrd_pkg::MINLEN_W) ? RL_W : bsrd_pkg::MINLEN_W;
   localparam int LHS_W = bsrd_pkg::RANGE_W + X10_W;
   localparam int RHS_W = bsrd_pkg::RATIO_W + SUM_W;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   logic [RL_W-1:0]  run_len_ff, run_len_in;
   logic [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic [X10_W-1:0] run_x10_ff, run_x10_in;   // run_len * 10, kept alongside

   logic [bsrd_pkg::MINLEN_W-1:0] minlen;
   logic             qualified;
   logic [CMP_W-1:0] lhs, lo_bound, hi_bound;
   logic             ok;

   always_comb begin
      minlen = (cfg.min_run_length == '0) ? bsrd_pkg::MINLEN_W'(1) : cfg.min_run_length;
      qualified = LEN_W'(run_len_ff) >= LEN_W'(minlen);
      lhs      = CMP_W'(item.kept) * CMP_W'(run_x10_ff);
      lo_bound = CMP_W'(cfg.ratio_low_tenths) * CMP_W'(run_sum_ff);
      hi_bound = CMP_W'(cfg.ratio_high_tenths) * CMP_W'(run_sum_ff);
      ok = (item.kept != '0) && (lhs > lo_bound) && (lhs < hi_bound);
      emit = step && item.proc && qualified && !ok;
   end

   always_comb begin
      run_len_in = run_len_ff;
      run_sum_in = run_sum_ff;
      run_x10_in = run_x10_ff;
      if (step) begin
         if (item.proc) begin
            if ((qualified && !ok) || (!qualified && item.kept == '0)) begin
               run_len_in = '0;
               run_sum_in = '0;
               run_x10_in = '0;
            end else begin
               run_len_in = run_len_ff + RL_W'(1);
               run_sum_in = run_sum_ff + SUM_W'(item.kept);
               run_x10_in = run_x10_ff + X10_W'(bsrd_pkg::TENTHS);
            end
         end
         // last of scan clears the run after the sample is handled
         if (item.last) begin
            run_len_in = '0;
            run_sum_in = '0;
            run_x10_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff <= '0;
         run_sum_ff <= '0;
         run_x10_ff <= '0;
      end else begin
         run_len_ff <= run_len_in;
         run_sum_ff <= run_sum_in;
         run_x10_ff <= run_x10_in;
      end
   end

endmodule

[rtl/background_subtract_run_detect.sv]
// Background-subtracting run detector for laser range scans.
// Request channel (req_): one range sample per request with an operation
// (learn or process) and a last-of-scan mark; the scan position comes from
// an internal counter. Result channel (rsp_): the index and kept range of a
// sample that ended a qualified run; zero or one result per request.
// Configuration goes through the csr_ APB-style port; the user must write it
// only while the block is idle, which the block does not enforce. Throughput:
// one request per cycle while req_stall is low. The background memory has one
// port with registered read data; a request passes three stages (accept and
// memory read, background compare, run update) on its way to rsp_valid.
// Reset clears the position, the learned flag, the run state and the result
// buffers and restores register defaults; the background memory is not
// cleared, so process requests have no effect until a scan has been learned.
// When rsp_stall holds a result, later results go to a one-entry skid buffer;
// once that is full req_stall rises and the pipeline freezes until the
// waiting result is taken.
// Depends on bsrd_pkg, bsrd_ram, bsrd_csr and bsrd_run.
module background_subtract_run_detect #(
   parameter int SCAN_LEN = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operation,
   input  logic [bsrd_pkg::RANGE_W-1:0]    req_range_mm,
   input  logic                            req_last_of_scan,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bsrd_pkg::INDEX_W-1:0]    rsp_end_index,
   output logic [bsrd_pkg::RANGE_W-1:0]    rsp_end_range,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bsrd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bsrd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bsrd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int POS_W  = $clog2(SCAN_LEN + 1);
   localparam int ADDR_W = $clog2(SCAN_LEN);

   bsrd_pkg::cfg_type cfg;

   logic adv, accept, in_range, mem_we;
   logic [bsrd_pkg::RANGE_W-1:0] bg;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             learned_ff, learned_in;

   // stage 1: memory read in flight
   logic                         s1_valid_ff;
   logic                         s1_proc_ff, s1_last_ff;
   logic [POS_W-1:0]             s1_pos_ff;
   logic [bsrd_pkg::RANGE_W-1:0] s1_range_ff;

   // stage 2: kept range known, run update
   logic                         s2_valid_ff;
   logic [POS_W-1:0]             s2_pos_ff;
   bsrd_pkg::item_type           s2_item_ff, s2_item_in;
   logic [bsrd_pkg::RANGE_W-1:0] diff;
   logic                         emit;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bsrd_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [bsrd_pkg::RANGE_W-1:0] rsp_range_ff, rsp_range_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic [bsrd_pkg::INDEX_W-1:0] skid_index_ff, skid_index_in;
   logic [bsrd_pkg::RANGE_W-1:0] skid_range_ff, skid_range_in;

   bsrd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign csr_pready = 1'b1;

   // pipeline moves whenever the skid entry is free
   assign adv      = !skid_valid_ff;
   assign accept   = req_valid && adv;
   assign in_range = pos_ff < POS_W'(SCAN_LEN);
   assign mem_we   = accept && in_range && (req_operation == bsrd_pkg::OP_LEARN);

   bsrd_ram #(
      .WIDTH (bsrd_pkg::RANGE_W),
      .DEPTH (SCAN_LEN)
   ) u_bg_ram (
      .clock (clock),
      .en    (accept),
      .we    (mem_we),
      .addr  (pos_ff[ADDR_W-1:0]),
      .wdata (req_range_mm),
      .rdata (bg)
   );

   always_comb begin
      pos_in     = pos_ff;
      learned_in = learned_ff;
      if (accept) begin
         if (mem_we && req_last_of_scan) begin
            learned_in = 1'b1;
         end
         if (req_last_of_scan) begin
            pos_in = '0;
         end else if (in_range) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      diff = (bg > s1_range_ff) ? (bg - s1_range_ff) : (s1_range_ff - bg);
      s2_item_in.proc = s1_valid_ff && s1_proc_ff;
      s2_item_in.last = s1_valid_ff && s1_last_ff;
      s2_item_in.kept = (diff < cfg.background_tolerance) ? '0 : s1_range_ff;
   end

   bsrd_run #(
      .SCAN_LEN (SCAN_LEN)
   ) u_run (
      .clock (clock),
      .reset (reset),
      .step  (adv && s2_valid_ff),
      .item  (s2_item_ff),
      .cfg   (cfg),
      .emit  (emit)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_range_in  = rsp_range_ff;
      skid_valid_in = skid_valid_ff;
      skid_index_in = skid_index_ff;
      skid_range_in = skid_range_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = skid_index_ff;
            rsp_range_in  = skid_range_ff;
            skid_valid_in = 1'b0;
         end else if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_index_in = bsrd_pkg::INDEX_W'(s2_pos_ff);
            rsp_range_in = s2_item_ff.kept;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_index_in = bsrd_pkg::INDEX_W'(s2_pos_ff);
         skid_range_in = s2_item_ff.kept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         learned_ff    <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         learned_ff    <= learned_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (adv) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff  <= rsp_index_in;
      rsp_range_ff  <= rsp_range_in;
      skid_index_ff <= skid_index_in;
      skid_range_ff <= skid_range_in;
      if (adv) begin
         s1_proc_ff  <= in_range && (req_operation == bsrd_pkg::OP_PROCESS) && learned_ff;
         s1_last_ff  <= req_last_of_scan;
         s1_pos_ff   <= pos_ff;
         s1_range_ff <= req_range_mm;
         s2_pos_ff   <= s1_pos_ff;
         s2_item_ff  <= s2_item_in;
      end
   end

   assign req_stall     = skid_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_end_index = rsp_index_ff;
   assign rsp_end_range = rsp_range_ff;

endmodule

[rtl/bsrd_checker.sv]
// Port-level checks for background_subtract_run_detect, attached by bind.
// Depends on bsrd_pkg for port widths.
module bsrd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bsrd_pkg::INDEX_W-1:0]    rsp_end_index,
   input logic [bsrd_pkg::RANGE_W-1:0]    rsp_end_range,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [bsrd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [bsrd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [bsrd_pkg::CSR_DATA_W-1:0] csr_prdata
);

   // reset empties the result buffers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result buffers not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_end_index)
         && $stable(rsp_end_range))
      else $error("stalled result changed");

   // back-pressure only while a result is waiting
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stall without a waiting result");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall raised without a stalled result");

   a_tolerance_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr == '0
      |=> csr_paddr != '0
         || csr_prdata[bsrd_pkg::TOL_W-1:0] == $past(csr_pwdata[bsrd_pkg::TOL_W-1:0]))
      else $error("tolerance register readback mismatch");

endmodule

bind background_subtract_run_detect bsrd_checker u_bsrd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_end_index (rsp_end_index),
   .rsp_end_range (rsp_end_range),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);
